### src/tbrd_pkg.sv
// Shared constants and types of the tile board run decoder.
package tbrd_pkg;

  localparam int unsigned BOARD_TILES_DEF = 4096;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned BUF_W   = 20;
  localparam int unsigned HELD_W  = 5;
  localparam int unsigned CODE_W  = 13;
  localparam int unsigned TILE_W  = 12;
  localparam int unsigned LEN_W   = 8;
  localparam int unsigned CALC_W  = 14;
  localparam int unsigned TDATA_W = 48;

  localparam logic [HELD_W-1:0] WIDE_CODE_BITS   = 5'd13;
  localparam logic [HELD_W-1:0] NARROW_CODE_BITS = 5'd12;
  localparam logic [HELD_W-1:0] BYTE_BITS        = 5'd8;
  localparam int unsigned       PAIR_BIT         = 8;

  typedef struct packed {
    logic [TILE_W-1:0] start_index;
    logic [LEN_W-1:0]  run_length;
    logic              pair_mode;
    logic [TILE_W-1:0] first_tile;
    logic [TILE_W-1:0] second_tile;
    logic              board_full;
  } run_t;

endpackage

### src/tbrd_core.sv
// Decoder state registers and the single-pass code and run logic.
module tbrd_core #(
  parameter int unsigned BOARD_TILES = tbrd_pkg::BOARD_TILES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_data_i,
  input  logic                        accept_i,
  input  logic [tbrd_pkg::BYTE_W-1:0] byte_i,
  input  logic                        new_board_i,
  output logic                        res_valid_o,
  output tbrd_pkg::run_t              res_o
);

  localparam int unsigned IDX_W = $clog2(BOARD_TILES + 1);
  localparam logic [tbrd_pkg::CALC_W-1:0] BOARD_C = tbrd_pkg::CALC_W'(BOARD_TILES);

  logic                        wide_q;
  logic [tbrd_pkg::BUF_W-1:0]  buf_q, buf_d;
  logic [tbrd_pkg::HELD_W-1:0] held_q, held_d;
  logic                        pair_q, pair_d;
  logic                        hvalid_q, hvalid_d;
  logic [tbrd_pkg::TILE_W-1:0] htile_q, htile_d;
  logic [tbrd_pkg::LEN_W-1:0]  rep_q, rep_d;
  logic [IDX_W-1:0]            idx_q, idx_d;
  logic                        fire;
  tbrd_pkg::run_t              res;

  always_comb begin
    logic [tbrd_pkg::BUF_W-1:0]  c_buf;
    logic [tbrd_pkg::HELD_W-1:0] c_held;
    logic                        c_pair;
    logic                        c_hvalid;
    logic [tbrd_pkg::TILE_W-1:0] c_htile;
    logic [tbrd_pkg::LEN_W-1:0]  c_rep;
    logic [IDX_W-1:0]            c_idx;
    logic [tbrd_pkg::CALC_W-1:0] idx_w, room, rep_w, len_w, idx_n;
    logic [tbrd_pkg::BUF_W-1:0]  nbuf;
    logic [tbrd_pkg::HELD_W-1:0] nheld, cwidth;
    logic [tbrd_pkg::CODE_W-1:0] code;
    logic                        is_ctrl;

    if (new_board_i) begin
      c_buf    = '0;
      c_held   = '0;
      c_pair   = 1'b0;
      c_hvalid = 1'b0;
      c_htile  = '0;
      c_rep    = tbrd_pkg::LEN_W'(1);
      c_idx    = '0;
    end else begin
      c_buf    = buf_q;
      c_held   = held_q;
      c_pair   = pair_q;
      c_hvalid = hvalid_q;
      c_htile  = htile_q;
      c_rep    = rep_q;
      c_idx    = idx_q;
    end

    buf_d    = c_buf;
    held_d   = c_held;
    pair_d   = c_pair;
    hvalid_d = c_hvalid;
    htile_d  = c_htile;
    rep_d    = c_rep;
    idx_d    = c_idx;
    fire     = 1'b0;
    res      = '0;

    idx_w  = tbrd_pkg::CALC_W'(c_idx);
    room   = BOARD_C - idx_w;
    rep_w  = tbrd_pkg::CALC_W'(c_rep);
    cwidth = wide_q ? tbrd_pkg::WIDE_CODE_BITS : tbrd_pkg::NARROW_CODE_BITS;
    nbuf   = c_buf | (tbrd_pkg::BUF_W'(byte_i) << c_held);
    nheld  = c_held + tbrd_pkg::BYTE_BITS;
    code   = wide_q ? nbuf[tbrd_pkg::CODE_W-1:0] : {1'b0, nbuf[tbrd_pkg::TILE_W-1:0]};
    is_ctrl = wide_q ? code[tbrd_pkg::CODE_W-1] : code[tbrd_pkg::TILE_W-1];
    len_w  = '0;
    idx_n  = idx_w;

    // A full board swallows bytes until the next new board.
    if (idx_w < BOARD_C) begin
      buf_d  = nbuf;
      held_d = nheld;
      if (nheld >= cwidth) begin
        buf_d  = wide_q ? (nbuf >> tbrd_pkg::CODE_W) : (nbuf >> tbrd_pkg::TILE_W);
        held_d = nheld - cwidth;
        if (is_ctrl) begin
          pair_d = code[tbrd_pkg::PAIR_BIT];
          rep_d  = code[tbrd_pkg::LEN_W-1:0];
        end else if (c_pair && !c_hvalid) begin
          htile_d  = code[tbrd_pkg::TILE_W-1:0];
          hvalid_d = 1'b1;
        end else begin
          fire = 1'b1;
          if (c_pair) begin
            len_w = (rep_w > (room >> 1)) ? (room >> 1) : rep_w;
            idx_n = idx_w + (len_w << 1);
            res.pair_mode   = 1'b1;
            res.first_tile  = c_htile;
            res.second_tile = code[tbrd_pkg::TILE_W-1:0];
            hvalid_d = 1'b0;
            htile_d  = '0;
            pair_d   = 1'b0;
          end else begin
            len_w = (rep_w > room) ? room : rep_w;
            idx_n = idx_w + len_w;
            res.first_tile = code[tbrd_pkg::TILE_W-1:0];
          end
          rep_d = tbrd_pkg::LEN_W'(1);
          idx_d = idx_n[IDX_W-1:0];
          res.start_index = idx_w[tbrd_pkg::TILE_W-1:0];
          res.run_length  = len_w[tbrd_pkg::LEN_W-1:0];
          res.board_full  = (idx_n >= BOARD_C);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q   <= 1'b1;
      buf_q    <= '0;
      held_q   <= '0;
      pair_q   <= 1'b0;
      hvalid_q <= 1'b0;
      htile_q  <= '0;
      rep_q    <= tbrd_pkg::LEN_W'(1);
      idx_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        wide_q <= cfg_data_i;
      end
      if (accept_i) begin
        buf_q    <= buf_d;
        held_q   <= held_d;
        pair_q   <= pair_d;
        hvalid_q <= hvalid_d;
        htile_q  <= htile_d;
        rep_q    <= rep_d;
        idx_q    <= idx_d;
      end
    end
  end

  assign res_valid_o = accept_i && fire;
  assign res_o       = res;

endmodule

### src/tbrd_skid.sv
// Result register with a skid stage so input transfers continue under a stall.
module tbrd_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tbrd_pkg::run_t push_data_i,
  output logic           can_push_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tbrd_pkg::run_t out_data_o
);

  logic           out_v_q;
  logic           skid_v_q;
  tbrd_pkg::run_t out_q;
  tbrd_pkg::run_t skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= push_i;
      end
    end else if (push_i) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      out_q <= skid_v_q ? skid_q : push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  assign can_push_o  = !skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

### src/tile_board_run_decoder_unit.sv
// Top level of the tile board run decoder: stream ports, core and result buffer.
// A byte that completes a tile code has its run registered in the result register.
// Throughput: one byte per cycle while the skid stage is free, set by the single-pass
// code logic between the decoder state registers and the result register.
// A two-entry result buffer takes one result under a stall, then holds the input back.
// Reset (rst_ni low, asynchronous) clears the decoder state and sets wide codes.
module tile_board_run_decoder_unit #(
  parameter int unsigned BOARD_TILES = tbrd_pkg::BOARD_TILES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write channel: bit 0 is wide_codes.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_data_i,
  // Input stream.
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i,  // [7:0] byte_in
  input  logic                         s_axis_tuser_i,  // [0] new_board
  // Output stream of run commands.
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [11:0] start_index, [19:12] run_length, [31:20] first_tile,
  // [43:32] second_tile, [47:44] zero
  output logic [tbrd_pkg::TDATA_W-1:0] m_axis_tdata_o,
  output logic                         m_axis_tuser_o,  // [0] pair_mode
  output logic                         m_axis_tlast_o   // board_full
);

  logic           accept;
  logic           res_valid;
  logic           can_push;
  tbrd_pkg::run_t res;
  tbrd_pkg::run_t out;

  // The register may be written at any time; the core takes it at once.
  assign cfg_ready_o = 1'b1;

  // An input transfer is taken whenever the skid stage is free, so a result
  // always has somewhere to go even if the output side is stalled.
  assign s_axis_tready_o = can_push;
  assign accept          = s_axis_tvalid_i && can_push;

  tbrd_core #(
    .BOARD_TILES(BOARD_TILES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata_i),
    .new_board_i (s_axis_tuser_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tbrd_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .can_push_o  (can_push),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out)
  );

  // Pack the run command into the output stream fields.
  assign m_axis_tdata_o = {4'b0000, out.second_tile, out.first_tile,
                           out.run_length, out.start_index};
  assign m_axis_tuser_o = out.pair_mode;
  assign m_axis_tlast_o = out.board_full;

endmodule

### src/tbrd_checker.sv
// Port-level checks of the tile board run decoder, bound to the top level.
module tbrd_checker #(
  parameter int unsigned BOARD_TILES = tbrd_pkg::BOARD_TILES_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready_o,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [tbrd_pkg::TDATA_W-1:0] m_axis_tdata_o,
  input logic                         m_axis_tuser_o,
  input logic                         m_axis_tlast_o
);

  logic [tbrd_pkg::CALC_W-1:0] run_end;

  assign run_end = tbrd_pkg::CALC_W'(m_axis_tdata_o[11:0])
                 + (m_axis_tuser_o ? (tbrd_pkg::CALC_W'(m_axis_tdata_o[19:12]) << 1)
                                   : tbrd_pkg::CALC_W'(m_axis_tdata_o[19:12]));

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped during a stall");

  a_skid_implies_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no result pending");

  a_single_second_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[43:32] == 12'd0)
    else $error("single run carries a second tile");

  a_run_in_board: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> run_end <= tbrd_pkg::CALC_W'(BOARD_TILES))
    else $error("run extends past the board end");

  a_full_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o && !m_axis_tuser_o
      |-> run_end == tbrd_pkg::CALC_W'(BOARD_TILES))
    else $error("board full flagged before the board end");

endmodule

bind tile_board_run_decoder_unit tbrd_checker #(
  .BOARD_TILES(BOARD_TILES)
) u_tbrd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

### tb/tile_board_run_decoder_unit_tb.sv
// Self-checking testbench for the tile board run decoder with code-level stimulus.
`timescale 1ns / 1ps

module tile_board_run_decoder_unit_tb;

  // Tiles on one board; the decoder under test keeps its default size.
  localparam int unsigned BOARD_SIZE = tbrd_pkg::BOARD_TILES_DEF;
  // Control bit and code mask for each code width.
  localparam logic [12:0] WIDE_CTRL    = 13'h1000;
  localparam logic [12:0] NARROW_CTRL  = 13'h0800;
  localparam logic [12:0] WIDE_MASK    = 13'h1FFF;
  localparam logic [12:0] NARROW_MASK  = 13'h0FFF;
  // Register-level bits that a control code may carry beyond mode and count.
  localparam logic [12:0] WIDE_SPARE   = 13'h0E00;
  localparam logic [12:0] NARROW_SPARE = 13'h0600;
  // Cycles allowed after the last result before the block counts as idle.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Generous bound on the whole run, far above the slowest correct run.
  localparam int unsigned CYCLE_LIMIT   = 200000;

  typedef struct {
    logic [7:0] data;
    logic       new_board;
  } stream_byte_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic                         cfg_data = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [7:0]                   s_tdata = '0;
  logic                         s_tuser = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [tbrd_pkg::TDATA_W-1:0] m_tdata;
  logic                         m_tuser;
  logic                         m_tlast;

  // Stimulus backlog, filled by the sequencer and drained by the driver.
  stream_byte_t   bytes_waiting[$];
  // Run commands that the decoder owes, oldest first.
  tbrd_pkg::run_t runs_due[$];

  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          failed = 1'b0;

  // Shadow of the decoder state, updated on every accepted byte transfer.
  logic        wide_mode = 1'b1;
  int unsigned bit_acc;
  int unsigned acc_bits;
  bit          pair_on;
  bit          tile_held_v;
  int unsigned tile_held;
  int unsigned rep_cnt;
  int unsigned tile_pos;

  // Code packer used by the stimulus generator: codes go in LSB-first, bytes come out.
  logic [63:0] pk_acc = '0;
  int unsigned pk_n = 0;
  int unsigned gen_w = 13;
  bit          nb_pending = 1'b0;

  tile_board_run_decoder_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Clears everything but the width register, as a new board does; reset also sets wide.
  task automatic clear_board();
    bit_acc     = 0;
    acc_bits    = 0;
    pair_on     = 1'b0;
    tile_held_v = 1'b0;
    tile_held   = 0;
    rep_cnt     = 1;
    tile_pos    = 0;
  endtask

  // Takes one accepted byte and queues the run command it completes, if any.
  task automatic decode_byte(input logic [7:0] din, input logic nb);
    int unsigned    cw;
    logic [12:0]    cmask;
    logic [12:0]    cbit;
    logic [12:0]    code;
    int unsigned    room;
    int unsigned    len;
    tbrd_pkg::run_t r;
    if (nb) begin
      clear_board();
    end
    // A full board swallows bytes until the next new board.
    if (tile_pos >= BOARD_SIZE) begin
      return;
    end
    cw    = wide_mode ? int'(tbrd_pkg::WIDE_CODE_BITS) : int'(tbrd_pkg::NARROW_CODE_BITS);
    cmask = wide_mode ? WIDE_MASK : NARROW_MASK;
    cbit  = wide_mode ? WIDE_CTRL : NARROW_CTRL;
    bit_acc  = (bit_acc | (int'(din) << acc_bits)) & 32'h000F_FFFF;
    acc_bits = acc_bits + int'(tbrd_pkg::BYTE_BITS);
    if (acc_bits < cw) begin
      return;
    end
    code     = bit_acc[12:0] & cmask;
    bit_acc  = bit_acc >> cw;
    acc_bits = acc_bits - cw;
    // A control code only sets the mode and the count; a held tile survives it.
    if ((code & cbit) != '0) begin
      pair_on = code[tbrd_pkg::PAIR_BIT];
      rep_cnt = 32'(code[7:0]);
      return;
    end
    room = BOARD_SIZE - tile_pos;
    r.start_index = tile_pos[tbrd_pkg::TILE_W-1:0];
    if (pair_on) begin
      // The first tile of a pair is only held; the second one makes the run.
      if (!tile_held_v) begin
        tile_held   = 32'(code);
        tile_held_v = 1'b1;
        return;
      end
      len = (rep_cnt > room / 2) ? room / 2 : rep_cnt;
      tile_pos      = tile_pos + 2 * len;
      r.pair_mode   = 1'b1;
      r.first_tile  = tile_held[tbrd_pkg::TILE_W-1:0];
      r.second_tile = code[tbrd_pkg::TILE_W-1:0];
      tile_held_v   = 1'b0;
      tile_held     = 0;
      pair_on       = 1'b0;
    end else begin
      len = (rep_cnt > room) ? room : rep_cnt;
      tile_pos      = tile_pos + len;
      r.pair_mode   = 1'b0;
      r.first_tile  = code[tbrd_pkg::TILE_W-1:0];
      r.second_tile = '0;
    end
    // Even a clipped or zero-length run is reported, and the count goes back to one.
    rep_cnt      = 1;
    r.run_length = len[tbrd_pkg::LEN_W-1:0];
    r.board_full = (tile_pos >= BOARD_SIZE);
    runs_due.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one byte transfer per handshake, random idle cycles between them.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : byte_driver
    stream_byte_t nxt;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        decode_byte(s_tdata, s_tuser);
      end
      // The bus is free once the present byte has gone or none is offered.
      if (!s_tvalid || s_tready) begin
        if (bytes_waiting.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = bytes_waiting.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nxt.data;
          s_tuser  <= nxt.new_board;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure and a field-by-field check of every run.
  // ---------------------------------------------------------------------------
  task automatic cmp_field(input string fname, input logic [31:0] want,
                           input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: run field %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, fname, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk_i) begin : run_monitor
    tbrd_pkg::run_t want;
    if (rst_ni) begin
      m_tready <= ($urandom_range(99) >= stall_pct);
      if (m_tvalid && m_tready) begin
        if (runs_due.size() == 0) begin
          $display("%0t: unexpected run, expected none, actual tdata 0x%0h tuser %0b tlast %0b",
                   $time, m_tdata, m_tuser, m_tlast);
          failed = 1'b1;
        end else begin
          want = runs_due.pop_front();
          cmp_field("start_index", 32'(want.start_index), 32'(m_tdata[11:0]));
          cmp_field("run_length", 32'(want.run_length), 32'(m_tdata[19:12]));
          cmp_field("first_tile", 32'(want.first_tile), 32'(m_tdata[31:20]));
          cmp_field("second_tile", 32'(want.second_tile), 32'(m_tdata[43:32]));
          cmp_field("tdata padding", 32'(0), 32'(m_tdata[47:44]));
          cmp_field("pair_mode", 32'(want.pair_mode), 32'(m_tuser));
          cmp_field("board_full", 32'(want.board_full), 32'(m_tlast));
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d runs outstanding", $time, runs_due.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b);
    stream_byte_t item;
    item.data      = b;
    item.new_board = nb_pending;
    nb_pending     = 1'b0;
    bytes_waiting.push_back(item);
  endtask

  // Appends one code at the generator's width and emits every whole byte.
  task automatic push_code(input logic [12:0] code);
    pk_acc = pk_acc | (64'(code) << pk_n);
    pk_n   = pk_n + gen_w;
    while (pk_n >= 8) begin
      push_byte(pk_acc[7:0]);
      pk_acc = pk_acc >> 8;
      pk_n   = pk_n - 8;
    end
  endtask

  // Emits the last part-filled byte with random filler in its upper bits.
  task automatic flush_codes();
    logic [7:0] filler;
    if (pk_n > 0) begin
      filler = 8'($urandom);
      push_byte(pk_acc[7:0] | (filler << pk_n));
    end
    pk_acc = '0;
    pk_n   = 0;
  endtask

  function automatic logic [7:0] pick_count();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) begin
      return 8'd0;
    end else if (r == 1) begin
      return 8'd255;
    end else if (r == 2) begin
      return 8'd1;
    end
    return 8'($urandom);
  endfunction

  function automatic logic [12:0] ctrl_code(input bit pair, input logic [7:0] cnt);
    logic [12:0] spare;
    spare = 13'($urandom) & ((gen_w == 13) ? WIDE_SPARE : NARROW_SPARE);
    return ((gen_w == 13) ? WIDE_CTRL : NARROW_CTRL) | spare
           | (13'(pair) << tbrd_pkg::PAIR_BIT) | 13'(cnt);
  endfunction

  function automatic logic [12:0] tile_code();
    return 13'($urandom) & ((gen_w == 13) ? 13'h0FFF : 13'h07FF);
  endfunction

  // One board's worth of runs, cut short once the byte goal is met; most runs are
  // well formed, some codes and bytes are noise.
  task automatic gen_board(input bit fresh, input int unsigned goal);
    int unsigned nruns;
    int unsigned r;
    nb_pending = fresh;
    nruns = $urandom_range(45, 4);
    repeat (nruns) begin
      if (bytes_waiting.size() >= goal) begin
        break;
      end
      r = $urandom_range(99);
      if (r < 50) begin
        if ($urandom_range(3) != 0) begin
          push_code(ctrl_code(1'b0, pick_count()));
        end
        push_code(tile_code());
      end else if (r < 85) begin
        push_code(ctrl_code(1'b1, pick_count()));
        push_code(tile_code());
        // A control code between the two tiles leaves the first one held.
        if ($urandom_range(9) == 0) begin
          push_code(ctrl_code($urandom_range(1), pick_count()));
        end
        push_code(tile_code());
      end else if (r < 93) begin
        push_code(tile_code());
      end else begin
        push_code(13'($urandom) & ((gen_w == 13) ? WIDE_MASK : NARROW_MASK));
      end
    end
    flush_codes();
    // Now and then a few stray bytes break the framing of the next codes.
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(3, 1)) begin
        push_byte(8'($urandom));
      end
    end
  endtask

  task automatic gen_bytes(input int unsigned budget, input bit first_fresh);
    int unsigned goal;
    bit          fresh;
    goal  = bytes_waiting.size() + budget;
    fresh = first_fresh;
    while (bytes_waiting.size() < goal) begin
      gen_board(fresh, goal);
      fresh = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  // Waits until every byte is in and every run is out, then lets the block settle.
  task automatic wait_drained();
    @(negedge clk_i);
    while (bytes_waiting.size() != 0 || s_tvalid || runs_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Register write on the configuration channel; only done with the decoder idle.
  task automatic write_wide(input logic w);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do begin
      @(posedge clk_i);
    end while (!(cfg_valid && cfg_ready));
    wide_mode = w;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic w, input int unsigned send_pct, input int unsigned st_pct,
                           input int unsigned budget, input bit fresh, input bit split);
    write_wide(w);
    send_idle_pct = send_pct;
    stall_pct     = st_pct;
    gen_w = w ? 13 : 12;
    @(negedge clk_i);
    if (split) begin
      // The sender holds off half way until the decoder has delivered everything.
      gen_bytes(budget / 2, fresh);
      wait_drained();
      gen_bytes(budget / 2, 1'b1);
    end else begin
      gen_bytes(budget, fresh);
    end
    wait_drained();
  endtask

  initial begin
    clear_board();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at wide codes: zero and full counts, a pair whose first tile
    // outlives a single-mode control code, and raw all-ones and all-zeros bytes.
    write_wide(1'b1);
    gen_w = 13;
    @(negedge clk_i);
    nb_pending = 1'b1;
    push_code(ctrl_code(1'b0, 8'd0));
    push_code(13'h0FFF);
    push_code(ctrl_code(1'b0, 8'd255));
    push_code(13'h0000);
    push_code(WIDE_MASK);
    push_code(13'h0ABC);
    push_code(ctrl_code(1'b0, 8'd3));
    push_code(13'h0555);
    push_code(ctrl_code(1'b1, 8'd2));
    push_code(13'h00F0);
    push_code(13'h0123);
    flush_codes();
    nb_pending = 1'b1;
    push_byte(8'hFF);
    push_byte(8'h00);
    wait_drained();

    // Random phases across both code widths and every idling pattern. The second
    // phase starts without a new board, so the width changes under held bits.
    run_phase(1'b1, 0, 0, 80, 1'b1, 1'b0);
    run_phase(1'b0, 58, 0, 100, 1'b0, 1'b0);
    run_phase(1'b1, 0, 58, 100, 1'b1, 1'b1);
    run_phase(1'b0, 18, 18, 100, 1'b1, 1'b0);
    run_phase(1'b1, 0, 0, 100, 1'b1, 1'b0);

    if (!failed && runs_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
